// File: rtl/rsmp_pkg.sv
// Shared types, constants and rounding function for the linear resampler.
package rsmp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 21;
    localparam int STEP_W   = 20;
    localparam int FRAC_W   = 16;
    localparam int LERP_W   = 34;
    localparam int MIX_W    = 35;

    localparam logic [PHASE_W-1:0] ONE_Q16 = 21'h010000;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_RATE_STEP   = 2'd0;
    localparam logic [1:0] REG_IN_CHANNEL  = 2'd1;
    localparam logic [1:0] REG_OUT_CHANNEL = 2'd2;

    localparam logic [1:0] CH_MONO = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
    } frame_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       last;
    } frame_out_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic in_mono;
        logic out_mono;
    } mix_ctrl_t;

    // Round num / 2^16 (or 2^17) to nearest, halves away from zero, then saturate.
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [MIX_W-1:0] num,
        input logic                    half_shift
    );
        logic [MIX_W-1:0] mag;
        logic [MIX_W:0]   biased;
        logic [MIX_W:0]   r;
        logic signed [SAMPLE_W-1:0] res;
        mag    = num[MIX_W-1] ? (~num + 35'd1) : num;
        biased = {1'b0, mag} + (half_shift ? 36'h10000 : 36'h08000);
        r      = half_shift ? (biased >> 17) : (biased >> 16);
        if (num[MIX_W-1])
        begin
            if (r > 36'd32768)
                res = SAT_MIN;
            else
                res = SAMPLE_W'(~r + 36'd1);
        end
        else
        begin
            if (r > 36'd32767)
                res = SAT_MAX;
            else
                res = r[SAMPLE_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/rsmp_lane.sv
// One interpolation lane: prev + (cur - prev) * frac in Q16, registered.
module rsmp_lane
    import rsmp_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] prev,
    input  logic signed [SAMPLE_W-1:0] cur,
    input  logic [FRAC_W-1:0]          frac,
    output logic signed [LERP_W-1:0]   value
);

    logic signed [SAMPLE_W:0]   diff;
    logic signed [FRAC_W:0]     frac_s;
    logic signed [LERP_W-1:0]   prod;
    logic signed [LERP_W-1:0]   base;
    logic signed [LERP_W-1:0]   value_next;
    logic signed [LERP_W-1:0]   value_reg;

    assign diff       = $signed({cur[SAMPLE_W-1], cur}) - $signed({prev[SAMPLE_W-1], prev});
    assign frac_s     = $signed({1'b0, frac});
    assign prod       = diff * frac_s;
    assign base       = $signed({{2{prev[SAMPLE_W-1]}}, prev, 16'h0000});
    assign value_next = base + prod;

    always_ff @(posedge clk)
    begin
        if (en)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: rtl/rsmp_merge.sv
// Merge stage: channel mixing, rounding and saturation into the output register.
module rsmp_merge
    import rsmp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  mix_ctrl_t                ctrl,
    input  logic signed [LERP_W-1:0] lane_left,
    input  logic signed [LERP_W-1:0] lane_right,
    output frame_out_t               result,
    output logic                     result_valid
);

    logic                       mix_down;
    logic signed [MIX_W-1:0]    ext_left;
    logic signed [MIX_W-1:0]    ext_right;
    logic signed [MIX_W-1:0]    left_num;
    logic signed [SAMPLE_W-1:0] left_val;
    logic signed [SAMPLE_W-1:0] right_val;
    frame_out_t                 result_next;
    frame_out_t                 result_reg;
    logic                       valid_reg;

    assign mix_down  = ctrl.out_mono && !ctrl.in_mono;
    assign ext_left  = $signed({lane_left[LERP_W-1], lane_left});
    assign ext_right = $signed({lane_right[LERP_W-1], lane_right});
    assign left_num  = mix_down ? (ext_left + ext_right) : ext_left;
    assign left_val  = round_sat(left_num, mix_down);
    assign right_val = round_sat(ext_right, 1'b0);

    always_comb
    begin
        result_next.out_left = left_val;
        result_next.last     = ctrl.last;
        if (ctrl.out_mono)
            result_next.out_right = '0;
        else if (ctrl.in_mono)
            result_next.out_right = left_val;
        else
            result_next.out_right = right_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

// File: rtl/linear_resampler_channel_mix_core.sv
// Top level of the linear resampler: phase control, two channel lanes and the merge stage.
//
// A source frame that produces n output frames (n from 0 up to MAX_OUTPUTS_PER_INPUT)
// holds the input side until its requests are done: one interpolation request is issued
// per cycle while the output does not stall, to the two lane multipliers, and the phase add
// for the next request is in the same cycle. The very first frame after reset only primes
// the store. Results pass the lane register, then the output register, after their
// request is issued, and a stalled output holds the whole request pipeline.
module linear_resampler_channel_mix_core
    import rsmp_pkg::*;
#(
    parameter int MAX_OUTPUTS_PER_INPUT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  frame_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output frame_out_t  out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [STEP_W-1:0] cfg_data
);

    localparam int CNT_W = (MAX_OUTPUTS_PER_INPUT > 1) ? $clog2(MAX_OUTPUTS_PER_INPUT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_OUTPUTS_PER_INPUT - 1);

    logic [STEP_W-1:0]  rate_step_reg;
    logic [1:0]         in_chan_reg;
    logic [1:0]         out_chan_reg;

    logic               busy_reg;
    logic               primed_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               s1_valid_reg;
    logic               s1_last_reg;

    logic signed [SAMPLE_W-1:0] prev_left_reg;
    logic signed [SAMPLE_W-1:0] prev_right_reg;
    logic signed [SAMPLE_W-1:0] cur_left_reg;
    logic signed [SAMPLE_W-1:0] cur_right_reg;

    logic               in_mono;
    logic               out_mono;
    logic               in_fire;
    logic               cfg_fire;
    logic signed [SAMPLE_W-1:0] in_right;
    logic               adv;
    logic               below_one;
    logic               issue;
    logic               issue_last;
    logic               skip_done;
    logic               finish;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] phase_wrap;

    logic signed [LERP_W-1:0] lane_left;
    logic signed [LERP_W-1:0] lane_right;
    mix_ctrl_t          mix_ctrl;

    assign in_mono   = (in_chan_reg == CH_MONO);
    assign out_mono  = (out_chan_reg == CH_MONO);
    assign in_ready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_right  = in_mono ? in_data.sample_left : in_data.sample_right;

    assign adv        = !out_valid || out_ready;
    assign below_one  = (phase_reg < ONE_Q16);
    assign issue      = busy_reg && below_one && adv;
    assign phase_next = phase_reg + {1'b0, rate_step_reg};
    assign issue_last = (phase_next >= ONE_Q16) || (cnt_reg == CNT_LAST);
    // Phase past one: subtract one; cap reached with the phase still below one: restart at zero
    assign phase_wrap = (phase_next >= ONE_Q16) ? (phase_next - ONE_Q16) : '0;
    assign skip_done  = busy_reg && !below_one;
    assign finish     = (issue && issue_last) || skip_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_step_reg <= STEP_W'(32'h10000);
            in_chan_reg   <= 2'd2;
            out_chan_reg  <= 2'd2;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_RATE_STEP:   rate_step_reg <= cfg_data;
                REG_IN_CHANNEL:  in_chan_reg   <= cfg_data[1:0];
                REG_OUT_CHANNEL: out_chan_reg  <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            primed_reg   <= 1'b0;
            phase_reg    <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                primed_reg <= 1'b1;
                busy_reg   <= primed_reg;
                cnt_reg    <= '0;
            end
            else if (issue)
            begin
                cnt_reg   <= cnt_reg + 1'b1;
                phase_reg <= issue_last ? phase_wrap : phase_next;
                if (issue_last)
                    busy_reg <= 1'b0;
            end
            else if (skip_done)
            begin
                phase_reg <= phase_reg - ONE_Q16;
                busy_reg  <= 1'b0;
            end
            if (adv)
                s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_left_reg  <= in_data.sample_left;
            cur_right_reg <= in_right;
        end
        // First frame goes straight to the store
        if (in_fire && !primed_reg)
        begin
            prev_left_reg  <= in_data.sample_left;
            prev_right_reg <= in_right;
        end
        else if (finish)
        begin
            prev_left_reg  <= cur_left_reg;
            prev_right_reg <= cur_right_reg;
        end
        if (adv)
            s1_last_reg <= issue_last;
    end

    rsmp_lane u_lane_left (
        .clk   (clk),
        .en    (adv),
        .prev  (prev_left_reg),
        .cur   (cur_left_reg),
        .frac  (phase_reg[FRAC_W-1:0]),
        .value (lane_left)
    );

    rsmp_lane u_lane_right (
        .clk   (clk),
        .en    (adv),
        .prev  (prev_right_reg),
        .cur   (cur_right_reg),
        .frac  (phase_reg[FRAC_W-1:0]),
        .value (lane_right)
    );

    always_comb
    begin
        mix_ctrl.valid    = s1_valid_reg;
        mix_ctrl.last     = s1_last_reg;
        mix_ctrl.in_mono  = in_mono;
        mix_ctrl.out_mono = out_mono;
    end

    rsmp_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .ctrl         (mix_ctrl),
        .lane_left    (lane_left),
        .lane_right   (lane_right),
        .result       (out_data),
        .result_valid (out_valid)
    );

    a_busy_primed: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> primed_reg)
        else $error("busy without a primed store");

    a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && primed_reg) |=> busy_reg)
        else $error("primed frame did not start iteration");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && issue_last) |=> !busy_reg)
        else $error("iteration continued after final request");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |=> s1_valid_reg)
        else $error("lane request lost under stall");

endmodule
